// ===== rtl/qoi_pkg.sv =====
// ---------------------------------------------------------------------------
// QOI decoder package
// Shared constants, types and helper functions of the QOI image decoder.
// ---------------------------------------------------------------------------
package qoi_pkg;

   localparam int MAX_DIMENSION = 16384;
   localparam int INDEX_ENTRIES = 64;
   localparam int INDEX_W       = $clog2(INDEX_ENTRIES);
   localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
   localparam int PIXELS_W      = 2 * DIM_W;
   localparam int RUN_W         = 7;

   localparam logic [7:0] OP_RGB  = 8'hFE;
   localparam logic [7:0] OP_RGBA = 8'hFF;

   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_MAGIC     = 2'd1;
   localparam logic [1:0] ERR_OVERSIZED = 2'd2;

   localparam logic [3:0] HDR_MAGIC_END  = 4'd4;
   localparam logic [3:0] HDR_WIDTH_END  = 4'd8;
   localparam logic [3:0] HDR_HEIGHT_END = 4'd12;
   localparam logic [3:0] HDR_CHANNELS   = 4'd12;
   localparam logic [3:0] HDR_LAST       = 4'd13;

   localparam logic [7:0]  CHANNELS_RGBA = 8'd4;
   localparam logic [31:0] PIXEL_RESET   = 32'h0000_00FF;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_OP,
      PH_RGB,
      PH_RGBA,
      PH_LUMA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_RUN
   } ctrl_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] n);
      logic [7:0] m;
      case (n)
         2'd0:    m = 8'h71;
         2'd1:    m = 8'h6F;
         2'd2:    m = 8'h69;
         default: m = 8'h66;
      endcase
      return m;
   endfunction

   // (3r + 5g + 7b + 11a) mod 64
   function automatic logic [INDEX_W-1:0] hash_of(input logic [31:0] px);
      logic [INDEX_W-1:0] h;
      h = INDEX_W'(3 * px[31:24]) + INDEX_W'(5 * px[23:16])
        + INDEX_W'(7 * px[15:8]) + INDEX_W'(11 * px[7:0]);
      return h;
   endfunction

endpackage

// ===== rtl/qoi_req_if.sv =====
// ---------------------------------------------------------------------------
// QOI byte channel
// Valid/ready channel carrying one file byte and the frame-start flag.
// ---------------------------------------------------------------------------
interface qoi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/qoi_rsp_if.sv =====
// ---------------------------------------------------------------------------
// QOI pixel channel
// Valid/ready channel carrying one decoded pixel or an error word.
// ---------------------------------------------------------------------------
interface qoi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       has_alpha;
   logic       run_last;
   logic       image_last;
   logic [1:0] error_code;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output has_alpha, output run_last, output image_last,
                   output error_code, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input has_alpha, input run_last, input image_last,
                   input error_code, output ready);
endinterface

// ===== rtl/qoi_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module qoi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qoi_image_decoder.sv =====
// ---------------------------------------------------------------------------
// QOI image decoder
// Parses a QOI header and decodes its chunks into pixels, one byte a word.
// ---------------------------------------------------------------------------
// The decoder takes one file byte per input word and gives decoded pixels
// on the output channel. A byte with frame_start set restarts decoding:
// header parse from that byte, previous pixel back to opaque black, colour
// table cleared at once through per-entry valid bits. Bad magic or a width
// or height above MAX_DIMENSION gives one error word, then bytes are dropped
// until the next frame start; bytes after the final pixel are dropped too.
// Order: a byte is accepted in S_IDLE and decoded in S_DECODE; a run byte
// of n pixels then gives its pixels one by one in S_RUN. The separate decode
// step covers the registered read of the 64-entry colour table RAM, which is
// read speculatively at the address in the low six bits of every accepted byte;
// each pixel passes through the single output register, so backpressure on rsp stalls decoding.
// ---------------------------------------------------------------------------
module qoi_image_decoder (
   input  logic             clock,
   input  logic             reset,
   qoi_req_if.sink          req,
   qoi_rsp_if.source        rsp
);

   qoi_pkg::ctrl_type                  ctrl_ff, ctrl_in;
   qoi_pkg::phase_type                 phase_ff, phase_in;
   logic [3:0]                         hcount_ff, hcount_in;
   logic [31:0]                        width_ff, width_in;
   logic [31:0]                        height_ff, height_in;
   logic [7:0]                         channels_ff, channels_in;
   logic [qoi_pkg::PIXELS_W-1:0]       pixels_left_ff, pixels_left_in;
   logic [31:0]                        prev_ff, prev_in;
   logic [qoi_pkg::INDEX_ENTRIES-1:0]  valid_ff, valid_in;
   logic [2:0]                         chunk_left_ff, chunk_left_in;
   logic [31:0]                        partial_ff, partial_in;
   logic [7:0]                         byte_ff, byte_in;
   logic [qoi_pkg::RUN_W-1:0]          run_left_ff, run_left_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [31:0]                        rsp_px_ff, rsp_px_in;
   logic                               rsp_has_alpha_ff, rsp_has_alpha_in;
   logic                               rsp_run_last_ff, rsp_run_last_in;
   logic                               rsp_image_last_ff, rsp_image_last_in;
   logic [1:0]                         rsp_err_ff, rsp_err_in;

   logic                               ram_wr_en;
   logic [qoi_pkg::INDEX_W-1:0]        ram_wr_addr;
   logic [31:0]                        ram_wr_data;
   logic [qoi_pkg::INDEX_W-1:0]        ram_rd_addr;
   logic [31:0]                        ram_rd_data;

   logic                               out_free;
   logic                               emit;
   logic [31:0]                        emit_px;
   logic                               emit_run_last;
   logic                               err_emit;
   logic [1:0]                         err_code;
   logic                               emit_last;
   logic [qoi_pkg::INDEX_W-1:0]        emit_hash;
   logic [7:0]                         luma_dg;
   logic [31:0]                        partial_next;

   // Colour table: one RAM, read at the accepted byte, written per pixel.
   qoi_ram #(
      .WIDTH (32),
      .DEPTH (qoi_pkg::INDEX_ENTRIES)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign req.ready    = (ctrl_ff == qoi_pkg::S_IDLE);
   // keep reading at the held byte while decode waits on the output
   assign ram_rd_addr  = (ctrl_ff == qoi_pkg::S_IDLE) ? req.data_byte[qoi_pkg::INDEX_W-1:0]
                                                      : byte_ff[qoi_pkg::INDEX_W-1:0];
   assign emit_last    = (pixels_left_ff == qoi_pkg::PIXELS_W'(1));
   assign luma_dg      = {2'b00, partial_ff[5:0]} - 8'd32;
   assign partial_next = {partial_ff[23:0], byte_ff};

   always_comb begin
      ctrl_in        = ctrl_ff;
      phase_in       = phase_ff;
      hcount_in      = hcount_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      channels_in    = channels_ff;
      pixels_left_in = pixels_left_ff;
      prev_in        = prev_ff;
      valid_in       = valid_ff;
      chunk_left_in  = chunk_left_ff;
      partial_in     = partial_ff;
      byte_in        = byte_ff;
      run_left_in    = run_left_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_px_in         = rsp_px_ff;
      rsp_has_alpha_in  = rsp_has_alpha_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_image_last_in = rsp_image_last_ff;
      rsp_err_in        = rsp_err_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;

      emit          = 1'b0;
      emit_px       = prev_ff;
      emit_run_last = 1'b1;
      err_emit      = 1'b0;
      err_code      = qoi_pkg::ERR_NONE;

      case (ctrl_ff)
         qoi_pkg::S_IDLE: begin
            if (req.valid) begin
               byte_in = req.data_byte;
               ctrl_in = qoi_pkg::S_DECODE;
               if (req.frame_start) begin
                  // restart: clear all decode state, table included
                  phase_in       = qoi_pkg::PH_HEADER;
                  hcount_in      = '0;
                  width_in       = '0;
                  height_in      = '0;
                  channels_in    = '0;
                  pixels_left_in = '0;
                  prev_in        = qoi_pkg::PIXEL_RESET;
                  valid_in       = '0;
                  chunk_left_in  = '0;
                  partial_in     = '0;
               end
            end
         end

         qoi_pkg::S_DECODE: begin
            // hold the byte until the output register can take a word
            if (out_free) begin
               ctrl_in = qoi_pkg::S_IDLE;
               case (phase_ff)
                  qoi_pkg::PH_HEADER: begin
                     hcount_in = hcount_ff + 4'd1;
                     if (hcount_ff < qoi_pkg::HDR_MAGIC_END) begin
                        if (byte_ff != qoi_pkg::magic_byte(hcount_ff[1:0])) begin
                           err_emit = 1'b1;
                           err_code = qoi_pkg::ERR_MAGIC;
                           phase_in = qoi_pkg::PH_DONE;
                        end
                     end else if (hcount_ff < qoi_pkg::HDR_WIDTH_END) begin
                        width_in = {width_ff[23:0], byte_ff};
                     end else if (hcount_ff < qoi_pkg::HDR_HEIGHT_END) begin
                        height_in = {height_ff[23:0], byte_ff};
                     end else if (hcount_ff == qoi_pkg::HDR_CHANNELS) begin
                        channels_in = byte_ff;
                     end else if (width_ff > 32'(qoi_pkg::MAX_DIMENSION) ||
                                  height_ff > 32'(qoi_pkg::MAX_DIMENSION)) begin
                        err_emit = 1'b1;
                        err_code = qoi_pkg::ERR_OVERSIZED;
                        phase_in = qoi_pkg::PH_DONE;
                     end else begin
                        pixels_left_in = width_ff[qoi_pkg::DIM_W-1:0]
                                       * height_ff[qoi_pkg::DIM_W-1:0];
                        phase_in = (pixels_left_in == '0) ? qoi_pkg::PH_DONE
                                                          : qoi_pkg::PH_OP;
                     end
                  end

                  qoi_pkg::PH_OP: begin
                     if (byte_ff == qoi_pkg::OP_RGB) begin
                        phase_in      = qoi_pkg::PH_RGB;
                        chunk_left_in = 3'd3;
                        partial_in    = '0;
                     end else if (byte_ff == qoi_pkg::OP_RGBA) begin
                        phase_in      = qoi_pkg::PH_RGBA;
                        chunk_left_in = 3'd4;
                        partial_in    = '0;
                     end else begin
                        case (byte_ff[7:6])
                           qoi_pkg::TAG_INDEX: begin
                              // entry never written since restart reads as zero
                              emit    = 1'b1;
                              emit_px = valid_ff[byte_ff[qoi_pkg::INDEX_W-1:0]]
                                        ? ram_rd_data : '0;
                           end
                           qoi_pkg::TAG_DIFF: begin
                              emit    = 1'b1;
                              emit_px = {prev_ff[31:24] + {6'd0, byte_ff[5:4]} - 8'd2,
                                         prev_ff[23:16] + {6'd0, byte_ff[3:2]} - 8'd2,
                                         prev_ff[15:8]  + {6'd0, byte_ff[1:0]} - 8'd2,
                                         prev_ff[7:0]};
                           end
                           qoi_pkg::TAG_LUMA: begin
                              phase_in      = qoi_pkg::PH_LUMA;
                              chunk_left_in = 3'd1;
                              partial_in    = {24'd0, byte_ff};
                           end
                           default: begin
                              run_left_in = {1'b0, byte_ff[5:0]} + qoi_pkg::RUN_W'(1);
                              ctrl_in     = qoi_pkg::S_RUN;
                           end
                        endcase
                     end
                  end

                  qoi_pkg::PH_LUMA: begin
                     phase_in      = qoi_pkg::PH_OP;
                     chunk_left_in = '0;
                     emit          = 1'b1;
                     emit_px = {prev_ff[31:24] + luma_dg + {4'd0, byte_ff[7:4]} - 8'd8,
                                prev_ff[23:16] + luma_dg,
                                prev_ff[15:8]  + luma_dg + {4'd0, byte_ff[3:0]} - 8'd8,
                                prev_ff[7:0]};
                  end

                  qoi_pkg::PH_RGB, qoi_pkg::PH_RGBA: begin
                     partial_in    = partial_next;
                     chunk_left_in = chunk_left_ff - 3'd1;
                     if (chunk_left_in == '0) begin
                        phase_in = qoi_pkg::PH_OP;
                        emit     = 1'b1;
                        emit_px  = (phase_ff == qoi_pkg::PH_RGB)
                                   ? {partial_ff[15:0], byte_ff, prev_ff[7:0]}
                                   : partial_next;
                     end
                  end

                  default: begin
                     // drop bytes after the image or an error
                  end
               endcase
            end
         end

         qoi_pkg::S_RUN: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_px       = prev_ff;
               emit_run_last = (run_left_ff == qoi_pkg::RUN_W'(1));
               run_left_in   = run_left_ff - qoi_pkg::RUN_W'(1);
               if (emit_run_last || emit_last) begin
                  ctrl_in = qoi_pkg::S_IDLE;
               end
            end
         end

         default: begin
            ctrl_in = qoi_pkg::S_IDLE;
         end
      endcase

      emit_hash = qoi_pkg::hash_of(emit_px);

      // pixel write-back: table, previous pixel, count, output register
      if (emit) begin
         ram_wr_en                = 1'b1;
         ram_wr_addr              = emit_hash;
         ram_wr_data              = emit_px;
         valid_in[emit_hash]      = 1'b1;
         prev_in                  = emit_px;
         pixels_left_in           = pixels_left_ff - qoi_pkg::PIXELS_W'(1);
         if (emit_last) begin
            phase_in = qoi_pkg::PH_DONE;
         end
         rsp_valid_in      = 1'b1;
         rsp_px_in         = emit_px;
         rsp_has_alpha_in  = (channels_ff == qoi_pkg::CHANNELS_RGBA);
         rsp_run_last_in   = emit_run_last || emit_last;
         rsp_image_last_in = emit_last;
         rsp_err_in        = qoi_pkg::ERR_NONE;
      end else if (err_emit) begin
         rsp_valid_in      = 1'b1;
         rsp_px_in         = '0;
         rsp_has_alpha_in  = 1'b0;
         rsp_run_last_in   = 1'b1;
         rsp_image_last_in = 1'b0;
         rsp_err_in        = err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= qoi_pkg::S_IDLE;
         phase_ff       <= qoi_pkg::PH_HEADER;
         hcount_ff      <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         channels_ff    <= '0;
         pixels_left_ff <= '0;
         prev_ff        <= qoi_pkg::PIXEL_RESET;
         valid_ff       <= '0;
         chunk_left_ff  <= '0;
         partial_ff     <= '0;
         run_left_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ctrl_ff        <= ctrl_in;
         phase_ff       <= phase_in;
         hcount_ff      <= hcount_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         channels_ff    <= channels_in;
         pixels_left_ff <= pixels_left_in;
         prev_ff        <= prev_in;
         valid_ff       <= valid_in;
         chunk_left_ff  <= chunk_left_in;
         partial_ff     <= partial_in;
         run_left_ff    <= run_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff           <= byte_in;
      rsp_px_ff         <= rsp_px_in;
      rsp_has_alpha_ff  <= rsp_has_alpha_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_image_last_ff <= rsp_image_last_in;
      rsp_err_ff        <= rsp_err_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.red        = rsp_px_ff[31:24];
   assign rsp.green      = rsp_px_ff[23:16];
   assign rsp.blue       = rsp_px_ff[15:8];
   assign rsp.alpha      = rsp_px_ff[7:0];
   assign rsp.has_alpha  = rsp_has_alpha_ff;
   assign rsp.run_last   = rsp_run_last_ff;
   assign rsp.image_last = rsp_image_last_ff;
   assign rsp.error_code = rsp_err_ff;

   // an error word always closes its byte and never ends an image
   a_error_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_err_ff != qoi_pkg::ERR_NONE)
         |-> rsp_run_last_ff && !rsp_image_last_ff)
      else $error("error word with bad run_last or image_last");

   // a run only proceeds while the image still has pixels to give
   a_run_phase : assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == qoi_pkg::S_RUN)
         |-> (phase_ff == qoi_pkg::PH_OP) && (run_left_ff != '0)
             && (pixels_left_ff != '0))
      else $error("run state outside chunk decode");

   // chunk phases never run with an exhausted pixel count
   a_pixels_left : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == qoi_pkg::PH_OP || phase_ff == qoi_pkg::PH_RGB ||
       phase_ff == qoi_pkg::PH_RGBA || phase_ff == qoi_pkg::PH_LUMA)
         |-> (pixels_left_ff != '0))
      else $error("chunk phase with no pixels left");

   // the final pixel leaves the decoder done
   a_image_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_image_last_ff |-> (phase_ff == qoi_pkg::PH_DONE))
      else $error("final pixel without done phase");

endmodule
